>>> sv/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> sv/rxs_pkg.sv
package rxs_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = 5;
  localparam int CMD_W  = 2;

  typedef logic [WORD_W-1:0] word_t;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_SEED     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FORWARD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BACKWARD = 2'd2;

  // Xorshift shift amounts.
  localparam int SHIFT_A = 11;
  localparam int SHIFT_B = 8;
  localparam int SHIFT_C = 19;

  // Seed chain multiplier and the state after reset.
  localparam word_t SEED_MULT    = 32'd1812433253;
  localparam word_t RESET_WORD_0 = 32'd1812433254;
  localparam word_t RESET_WORD_1 = 32'd3713160357;
  localparam word_t RESET_WORD_2 = 32'd3109174145;
  localparam word_t RESET_WORD_3 = 32'd64984499;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    word_t            seed_value;
    logic             use_range;
    word_t            range_low;
    word_t            range_high;
  } in_item_t;

  typedef struct packed {
    word_t random_word;
    word_t ranged_word;
    logic  span_error;
  } out_item_t;

endpackage

>>> sv/reversible_xorshift128_generator.sv
// Step without range use: the result passes through the S_DONE state into the output register.
// Step with range use and a nonempty span: the result waits in S_MOD for the remainder unit.
// Seed: four chained passes of the bit-serial seed multiplier rebuild the state.
// The input stalls until the result enters the output register and the sequencer returns to S_IDLE.
// Synchronous active-low reset loads the fixed initial generator state and empties the output.
`include "assert_macros.svh"

module reversible_xorshift128_generator
  import rxs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SEED = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  word_t      words_r [4];
  word_t      words_nxt [4];
  logic [1:0] seed_idx_r, seed_idx_nxt;
  word_t      low_r, low_nxt;
  word_t      high_r, high_nxt;
  out_item_t  res_r, res_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;

  logic  in_accept;
  word_t fwd_a, fwd_b, fresh;
  word_t bwd_a, bwd_b, lost;
  word_t raw_sel;
  word_t span;
  logic  span_ok;
  word_t seed_w;
  logic  mul_start, mul_done;
  word_t mul_x, mul_prod;
  logic  div_start, div_done;
  word_t div_dividend, div_divisor, div_rem;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Forward xorshift step.
  assign fwd_a = words_r[0] ^ (words_r[0] << SHIFT_A);
  assign fwd_b = fwd_a ^ (fwd_a >> SHIFT_B);
  assign fresh = words_r[3] ^ (words_r[3] >> SHIFT_C) ^ fwd_b;

  // Backward step: undo the right shift by 8, then the left shift by 11.
  assign bwd_a = words_r[3] ^ words_r[2] ^ (words_r[2] >> SHIFT_C);
  assign bwd_b = bwd_a ^ (bwd_a >> SHIFT_B) ^ (bwd_a >> (2 * SHIFT_B))
               ^ (bwd_a >> (3 * SHIFT_B));
  assign lost  = bwd_b ^ (bwd_b << SHIFT_A) ^ (bwd_b << (2 * SHIFT_A));

  assign raw_sel = (in_data.command == CMD_FORWARD) ? fresh : words_r[3];
  assign span_ok = in_data.range_high > in_data.range_low;
  assign span    = in_data.range_high - in_data.range_low;

  // Seed chain word for the current index.
  assign seed_w = mul_prod + word_t'(seed_idx_r) + word_t'(1);

  // Sequencer and generator state update.
  always_comb begin
    state_nxt     = state_r;
    words_nxt     = words_r;
    seed_idx_nxt  = seed_idx_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mul_start     = 1'b0;
    mul_x         = '0;
    div_start     = 1'b0;
    div_dividend  = raw_sel;
    div_divisor   = span;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          low_nxt   = in_data.range_low;
          high_nxt  = in_data.range_high;
          res_nxt   = '0;
          state_nxt = S_DONE;
          case (in_data.command)
            CMD_SEED: begin
              mul_start    = 1'b1;
              mul_x        = in_data.seed_value ^ (in_data.seed_value >> 30);
              seed_idx_nxt = '0;
              state_nxt    = S_SEED;
            end
            CMD_FORWARD: begin
              words_nxt[0] = words_r[1];
              words_nxt[1] = words_r[2];
              words_nxt[2] = words_r[3];
              words_nxt[3] = fresh;
            end
            CMD_BACKWARD: begin
              words_nxt[3] = words_r[2];
              words_nxt[2] = words_r[1];
              words_nxt[1] = words_r[0];
              words_nxt[0] = lost;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
          // Stepping commands produce a word and maybe a ranged result.
          if (in_data.command == CMD_FORWARD || in_data.command == CMD_BACKWARD) begin
            res_nxt.random_word = raw_sel;
            if (in_data.use_range) begin
              if (span_ok) begin
                div_start = 1'b1;
                state_nxt = S_MOD;
              end else begin
                res_nxt.ranged_word = in_data.range_low;
                res_nxt.span_error  = 1'b1;
              end
            end
          end
        end
      end
      S_SEED: begin
        if (mul_done) begin
          words_nxt[seed_idx_r] = seed_w;
          if (seed_idx_r == 2'd3) begin
            state_nxt = S_DONE;
          end else begin
            seed_idx_nxt = seed_idx_r + 2'd1;
            mul_start    = 1'b1;
            mul_x        = seed_w ^ (seed_w >> 30);
          end
        end
      end
      S_MOD: begin
        if (div_done) begin
          res_nxt.ranged_word = low_r + div_rem;
          state_nxt           = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and generator state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      seed_idx_r  <= '0;
      words_r[0]  <= RESET_WORD_0;
      words_r[1]  <= RESET_WORD_1;
      words_r[2]  <= RESET_WORD_2;
      words_r[3]  <= RESET_WORD_3;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      seed_idx_r  <= seed_idx_nxt;
      words_r     <= words_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    low_r      <= low_nxt;
    high_r     <= high_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  rxs_seed_mult u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .operand (mul_x),
    .done    (mul_done),
    .product (mul_prod)
  );

  rxs_remainder u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The remainder pass only runs with a nonempty span.
  `ASSERT_IMPL(a_mod_span, clk, rst_n, state_r == S_MOD, high_r > low_r)
  // Serial units finish only while the sequencer waits for them.
  `ASSERT_IMPL(a_mul_in_seed, clk, rst_n, mul_done, state_r == S_SEED)
  `ASSERT_IMPL(a_div_in_mod, clk, rst_n, div_done, state_r == S_MOD)
  // A finished result moves into a free output register.
  `ASSERT_NEXT(a_done_loads, clk, rst_n, state_r == S_DONE && !(out_valid && out_stall), out_valid)

endmodule

>>> sv/rxs_seed_mult.sv
module rxs_seed_mult
  import rxs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t operand,
  output logic  done,
  output word_t product
);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  word_t            x_r;
  word_t            mc_r;
  word_t            acc_r;
  word_t            acc_nxt;

  // One multiplier bit per cycle: add the shifted operand when the bit is set.
  assign acc_nxt = acc_r + (mc_r[0] ? x_r : '0);

  // Control: run for one pass over the multiplier bits, then pulse done.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(WORD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= operand;
      mc_r  <= SEED_MULT;
      acc_r <= '0;
    end else if (run_r) begin
      x_r   <= {x_r[WORD_W-2:0], 1'b0};
      mc_r  <= {1'b0, mc_r[WORD_W-1:1]};
      acc_r <= acc_nxt;
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

>>> sv/rxs_remainder.sv
module rxs_remainder
  import rxs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t dividend,
  input  word_t divisor,
  output logic  done,
  output word_t remainder
);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  word_t            quo_r;
  word_t            rem_r;
  word_t            div_r;
  logic [WORD_W:0]  shifted;
  logic [WORD_W:0]  diff;
  word_t            rem_nxt;

  // Restoring step: bring in the next dividend bit, subtract when it fits.
  assign shifted = {rem_r, quo_r[WORD_W-1]};
  assign diff    = shifted - {1'b0, div_r};
  assign rem_nxt = diff[WORD_W] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];

  // Control: one dividend bit per cycle, then pulse done.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(WORD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[WORD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

>>> verif/reversible_xorshift128_generator_tb.sv
`timescale 1ns / 1ps

module reversible_xorshift128_generator_tb;
  import rxs_pkg::*;

  // The command encoding that the block leaves unused.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Cycles without any transfer before the run is declared hung.
  localparam int QUIET_LIMIT   = 4000;
  // Seeding is the slowest operation.
  localparam int SETTLE_CYCLES = 300;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_ITEMS  = 1100;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count    = 0;
  int quiet_cycles  = 0;

  // Predicted generator state and the draws still owed by the block.
  word_t     gen_words [4];
  out_item_t expected_draws [$];

  reversible_xorshift128_generator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Applies one command to the predicted state and returns the draw it yields.
  function automatic out_item_t xorshift_predict(input in_item_t item);
    out_item_t res;
    word_t     draw;
    word_t     t;
    word_t     last;
    word_t     prev;
    word_t     w;
    int        i;
    res = '0;
    draw = '0;
    case (item.command)
      CMD_SEED: begin
        w = item.seed_value;
        for (i = 1; i <= 4; i++) begin
          w = SEED_MULT * (w ^ (w >> 30)) + word_t'(i);
          gen_words[i-1] = w;
        end
        return res;
      end
      CMD_FORWARD: begin
        t = gen_words[0];
        last = gen_words[3];
        t = t ^ (t << SHIFT_A);
        t = t ^ (t >> SHIFT_B);
        draw = last ^ (last >> SHIFT_C) ^ t;
        gen_words[0] = gen_words[1];
        gen_words[1] = gen_words[2];
        gen_words[2] = last;
        gen_words[3] = draw;
      end
      CMD_BACKWARD: begin
        draw = gen_words[3];
        prev = gen_words[2];
        t = draw ^ prev ^ (prev >> SHIFT_C);
        // Undo the right xor-shift by 8, then the left xor-shift by 11.
        t = t ^ (t >> 8) ^ (t >> 16) ^ (t >> 24);
        t = t ^ (t << 11) ^ (t << 22);
        gen_words[3] = prev;
        gen_words[2] = gen_words[1];
        gen_words[1] = gen_words[0];
        gen_words[0] = t;
      end
      default: begin
        return res;
      end
    endcase
    res.random_word = draw;
    if (item.use_range) begin
      if (item.range_high <= item.range_low) begin
        res.ranged_word = item.range_low;
        res.span_error  = 1'b1;
      end else begin
        res.ranged_word = item.range_low + draw % (item.range_high - item.range_low);
      end
    end
    return res;
  endfunction

  function automatic in_item_t make_item(input logic [CMD_W-1:0] cmd, input word_t seed,
                                         input logic range_on, input word_t low,
                                         input word_t high);
    in_item_t item;
    item.command    = cmd;
    item.seed_value = seed;
    item.use_range  = range_on;
    item.range_low  = low;
    item.range_high = high;
    return item;
  endfunction

  // Random content for one command, with range bounds of several shapes.
  function automatic in_item_t rand_item(input logic [CMD_W-1:0] cmd);
    in_item_t item;
    item.command    = cmd;
    item.seed_value = $urandom;
    item.use_range  = 1'($urandom_range(1));
    item.range_low  = $urandom;
    case ($urandom_range(3))
      0: item.range_high = $urandom;
      1: item.range_high = item.range_low + word_t'($urandom_range(300, 1));
      2: item.range_high = item.range_low - word_t'($urandom_range(5));
      default: begin
        item.range_low  = $urandom_range(1) ? '0 : '1;
        item.range_high = $urandom_range(1) ? '1 : word_t'($urandom);
      end
    endcase
    return item;
  endfunction

  task automatic note_failure(input string msg);
    if (fail_count < MAX_REPORTS) begin
      $display("%s", msg);
    end
    fail_count++;
  endtask

  // Presents one item after a random gap and records its draw once the transfer happens.
  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expected_draws.push_back(xorshift_predict(item));
  endtask

  // Holds the input idle until every owed draw has come out.
  task automatic wait_for_draws();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (expected_draws.size() != 0);
  endtask

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Compare each result transfer with the oldest predicted draw.
  always @(posedge clk) begin : draw_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_draws.size() == 0) begin
        note_failure($sformatf("unexpected result: random %h ranged %h err %b",
                               out_data.random_word, out_data.ranged_word,
                               out_data.span_error));
      end else begin
        want = expected_draws.pop_front();
        if (out_data.random_word !== want.random_word ||
            out_data.ranged_word !== want.ranged_word ||
            out_data.span_error !== want.span_error) begin
          note_failure($sformatf(
            "mismatch: expected random %h ranged %h err %b, got random %h ranged %h err %b",
            want.random_word, want.ranged_word, want.span_error,
            out_data.random_word, out_data.ranged_word, out_data.span_error));
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Steps straight out of reset, so the reset state shows in the draws.
  task automatic test_reset_state();
    send_item(make_item(CMD_FORWARD, '0, 1'b0, '0, '0));
    send_item(make_item(CMD_FORWARD, '0, 1'b0, '0, '0));
    send_item(make_item(CMD_BACKWARD, '0, 1'b0, '0, '0));
    send_item(make_item(CMD_BACKWARD, '0, 1'b0, '0, '0));
    send_item(make_item(CMD_BACKWARD, '0, 1'b0, '0, '0));
  endtask

  // Every command, the seed extremes, and the fields that must read as zero.
  task automatic test_commands();
    send_item(make_item(CMD_SEED, '0, 1'b0, '0, '0));
    send_item(make_item(CMD_FORWARD, '1, 1'b0, '1, '1));
    send_item(make_item(CMD_SEED, '1, 1'b1, 32'd9, 32'd3));
    send_item(make_item(CMD_BACKWARD, '0, 1'b0, 32'd100, 32'd200));
    send_item(make_item(CMD_UNUSED, '1, 1'b1, '1, '1));
    send_item(make_item(CMD_UNUSED, '0, 1'b1, 32'd5, 32'd0));
    send_item(make_item(CMD_FORWARD, '0, 1'b0, '0, '0));
  endtask

  // Empty spans, a span of one, and the widest spans, in both directions.
  task automatic test_range_edges();
    send_item(make_item(CMD_FORWARD, '0, 1'b1, '0, '0));
    send_item(make_item(CMD_BACKWARD, '0, 1'b1, 32'd5, 32'd5));
    send_item(make_item(CMD_FORWARD, '0, 1'b1, '1, '0));
    send_item(make_item(CMD_FORWARD, '0, 1'b1, '0, 32'd1));
    send_item(make_item(CMD_BACKWARD, '0, 1'b1, '0, '1));
    send_item(make_item(CMD_FORWARD, '0, 1'b1, 32'hFFFF_FFFE, '1));
    send_item(make_item(CMD_BACKWARD, '0, 1'b1, 32'd7, 32'd8));
    send_item(make_item(CMD_FORWARD, '0, 1'b1, 32'h8000_0000, '1));
    send_item(make_item(CMD_BACKWARD, '0, 1'b1, 32'd1, 32'h8000_0001));
  endtask

  // Mostly single steps and there-and-back runs, with seeds and unused codes mixed in.
  task automatic test_random_walk(input int count);
    int sent;
    int run;
    int k;
    int pick;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 8) begin
        run = $urandom_range(12, 1);
        for (k = 0; k < run; k++) send_item(rand_item(CMD_FORWARD));
        for (k = 0; k < run; k++) send_item(rand_item(CMD_BACKWARD));
        sent += 2 * run;
      end else begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          send_item(rand_item(CMD_SEED));
        end else if (pick < 9) begin
          send_item(rand_item(CMD_UNUSED));
        end else if (pick < 55) begin
          send_item(rand_item(CMD_FORWARD));
        end else begin
          send_item(rand_item(CMD_BACKWARD));
        end
        sent++;
      end
      if ($urandom_range(99) == 0) begin
        wait_for_draws();
      end
    end
  endtask

  initial begin
    gen_words[0] = RESET_WORD_0;
    gen_words[1] = RESET_WORD_1;
    gen_words[2] = RESET_WORD_2;
    gen_words[3] = RESET_WORD_3;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Slow receiver first.
    send_idle_pct = 18;
    recv_idle_pct = 84;
    test_reset_state();
    test_commands();
    test_range_edges();
    test_random_walk(RANDOM_ITEMS / 3);
    wait_for_draws();

    // Then a slow sender.
    send_idle_pct = 84;
    recv_idle_pct = 18;
    test_random_walk(RANDOM_ITEMS / 3);
    wait_for_draws();

    // Then back-to-back transfers on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_walk(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    wait_for_draws();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_draws.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_draws.size()));
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
